[src/quaternion_arith_unit_macros.svh]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_MACROS_SVH
`define QUATERNION_ARITH_UNIT_MACROS_SVH

// same-cycle implication
`define QAU_ASSERT_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("quaternion_arith_unit: check failed");

// next-cycle implication
`define QAU_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("quaternion_arith_unit: check failed");

`endif

[src/qau_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Command and status codes and the item types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qau_pkg;

    typedef enum logic [1:0]
    {
        CMD_PRODUCT   = 2'd0,
        CMD_CONJUGATE = 2'd1,
        CMD_NORMALIZE = 2'd2,
        CMD_ROTATE    = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef struct packed
    {
        cmd_t               cmd;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } op_t;

    typedef struct packed
    {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic [30:0]        norm_out;
        logic [1:0]         status;
    } res_t;

endpackage

[src/quaternion_arith_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Hamilton product, conjugate, normalize and vector rotate in fixed point.
// ----------------------------------------------------------------------------
// Takes one item per cycle while no result is stalled; every item passes
// through the same stages, whatever its command. The pipeline length is set
// by the 32-stage square root and the FRAC_BITS + 1 stage divider used by
// normalize; the other commands ride along the same pipeline. A stalled result
// freezes the whole pipeline; op_stall rises in the same cycle as res_stall while res_valid is high.
`timescale 1ns / 1ps
`include "quaternion_arith_unit_macros.svh"

module quaternion_arith_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_stall,
    input  qau_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_stall,
    output qau_pkg::res_t res
);

    localparam int DS     = FRAC_BITS + 1;
    localparam int NW     = 33 + FRAC_BITS;
    localparam int SQS    = 32;
    localparam int NCARRY = SQS + 2 + DS;
    localparam int NSTAGE = SQS + 7 + DS;
    localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] ONE  = 68'sd1 <<< FRAC_BITS;

    typedef struct packed
    {
        qau_pkg::cmd_t    cmd;
        logic [3:0][31:0] a;
        logic [2:0][31:0] v;
    } front_t;

    typedef struct packed
    {
        logic [3:0][31:0] rp;
        logic             rp_sat;
        logic             coef_sat;
        logic [63:0]      ssum;
        logic             wrap;
    } mid_t;

    typedef struct packed
    {
        qau_pkg::cmd_t    cmd;
        logic [3:0][31:0] r;
        logic             sat;
        logic [63:0]      ssum;
        logic             wrap;
    } carry_t;

    function automatic logic signed [67:0] rnd(input logic signed [67:0] x);
        return (x + HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic [32:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        if (x < -68'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, x[31:0]};
    endfunction

    logic adv;
    logic [NSTAGE-1:0] v_reg;

    qau_pkg::op_t       in_reg;
    front_t             f2_reg, f3_reg, f4_reg;
    logic signed [63:0] pp_reg [16];
    logic signed [63:0] sq_reg [4];
    logic signed [63:0] cr_reg [6];
    mid_t               m3_reg, m4_reg;
    mid_t               m3_next;
    logic [31:0]        coef_reg [9];
    logic [31:0]        coef_next [9];
    logic signed [63:0] rot_reg [9];

    carry_t             carry_reg [NCARRY];
    carry_t             c0_next;
    logic [33:0]        rem_reg [SQS+1];
    logic [31:0]        root_reg [SQS+1];
    logic [33:0]        rem_next [SQS];
    logic [31:0]        root_next [SQS];

    logic [32:0]        nn_reg [DS+1];
    logic [32:0]        nn_next;
    logic [3:0][32:0]   drem_reg [DS+1];
    logic [3:0][DS-1:0] dnum_reg [DS+1];
    logic [3:0][DS-1:0] dq_reg [DS+1];
    logic [3:0][32:0]   drem_init;
    logic [3:0][DS-1:0] dnum_init;
    logic [3:0][32:0]   drem_next [DS];
    logic [3:0][DS-1:0] dq_next [DS];

    qau_pkg::res_t      res_reg, res_next;

    assign res_valid = v_reg[NSTAGE-1];
    assign adv       = !(res_valid && res_stall);
    assign op_stall  = !adv;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSTAGE-2:0], op_valid};
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= op;
            f2_reg.cmd <= in_reg.cmd;
            f2_reg.a <= {in_reg.a_z, in_reg.a_y, in_reg.a_x, in_reg.a_w};
            f2_reg.v <= {in_reg.b_z, in_reg.b_y, in_reg.b_x};
            pp_reg[0]  <= in_reg.a_w * in_reg.b_w;
            pp_reg[1]  <= in_reg.a_x * in_reg.b_x;
            pp_reg[2]  <= in_reg.a_y * in_reg.b_y;
            pp_reg[3]  <= in_reg.a_z * in_reg.b_z;
            pp_reg[4]  <= in_reg.a_w * in_reg.b_x;
            pp_reg[5]  <= in_reg.a_x * in_reg.b_w;
            pp_reg[6]  <= in_reg.a_y * in_reg.b_z;
            pp_reg[7]  <= in_reg.a_z * in_reg.b_y;
            pp_reg[8]  <= in_reg.a_w * in_reg.b_y;
            pp_reg[9]  <= in_reg.a_x * in_reg.b_z;
            pp_reg[10] <= in_reg.a_y * in_reg.b_w;
            pp_reg[11] <= in_reg.a_z * in_reg.b_x;
            pp_reg[12] <= in_reg.a_w * in_reg.b_z;
            pp_reg[13] <= in_reg.a_x * in_reg.b_y;
            pp_reg[14] <= in_reg.a_y * in_reg.b_x;
            pp_reg[15] <= in_reg.a_z * in_reg.b_w;
            sq_reg[0] <= in_reg.a_w * in_reg.a_w;
            sq_reg[1] <= in_reg.a_x * in_reg.a_x;
            sq_reg[2] <= in_reg.a_y * in_reg.a_y;
            sq_reg[3] <= in_reg.a_z * in_reg.a_z;
            cr_reg[0] <= in_reg.a_w * in_reg.a_x;
            cr_reg[1] <= in_reg.a_w * in_reg.a_y;
            cr_reg[2] <= in_reg.a_w * in_reg.a_z;
            cr_reg[3] <= in_reg.a_x * in_reg.a_y;
            cr_reg[4] <= in_reg.a_x * in_reg.a_z;
            cr_reg[5] <= in_reg.a_y * in_reg.a_z;
        end
    end

    // sum stage: product rows, rotation coefficients, sum of squares
    always_comb
    begin
        logic [32:0] t0, t1, t2, t3;
        logic [32:0] c [9];
        logic [65:0] s;
        t0 = sat32(rnd(68'(pp_reg[0]) - 68'(pp_reg[1]) - 68'(pp_reg[2]) - 68'(pp_reg[3])));
        t1 = sat32(rnd(68'(pp_reg[4]) + 68'(pp_reg[5]) + 68'(pp_reg[6]) - 68'(pp_reg[7])));
        t2 = sat32(rnd(68'(pp_reg[8]) - 68'(pp_reg[9]) + 68'(pp_reg[10]) + 68'(pp_reg[11])));
        t3 = sat32(rnd(68'(pp_reg[12]) + 68'(pp_reg[13]) - 68'(pp_reg[14]) + 68'(pp_reg[15])));
        c[0] = sat32(ONE - (rnd(68'(sq_reg[2]) + 68'(sq_reg[3])) <<< 1));
        c[1] = sat32(rnd(68'(cr_reg[2]) + 68'(cr_reg[3])) <<< 1);
        c[2] = sat32(rnd(68'(cr_reg[4]) - 68'(cr_reg[1])) <<< 1);
        c[3] = sat32(rnd(68'(cr_reg[3]) - 68'(cr_reg[2])) <<< 1);
        c[4] = sat32(ONE - (rnd(68'(sq_reg[1]) + 68'(sq_reg[3])) <<< 1));
        c[5] = sat32(rnd(68'(cr_reg[0]) + 68'(cr_reg[5])) <<< 1);
        c[6] = sat32(rnd(68'(cr_reg[1]) + 68'(cr_reg[4])) <<< 1);
        c[7] = sat32(rnd(68'(cr_reg[5]) - 68'(cr_reg[0])) <<< 1);
        c[8] = sat32(ONE - (rnd(68'(sq_reg[1]) + 68'(sq_reg[2])) <<< 1));
        s = 66'(sq_reg[0][62:0]) + 66'(sq_reg[1][62:0])
          + 66'(sq_reg[2][62:0]) + 66'(sq_reg[3][62:0]);
        m3_next.rp = {t3[31:0], t2[31:0], t1[31:0], t0[31:0]};
        m3_next.rp_sat = t0[32] | t1[32] | t2[32] | t3[32];
        m3_next.coef_sat = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            coef_next[i] = c[i][31:0];
            m3_next.coef_sat = m3_next.coef_sat | c[i][32];
        end
        m3_next.ssum = s[63:0];
        m3_next.wrap = |s[65:64];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg <= f2_reg;
            m3_reg <= m3_next;
            coef_reg <= coef_next;
            f4_reg <= f3_reg;
            m4_reg <= m3_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    rot_reg[3*i+j] <= $signed(coef_reg[3*i+j]) * $signed(f3_reg.v[j]);
        end
    end

    // rotate dot products and command select
    always_comb
    begin
        logic [32:0] d [3];
        logic [32:0] n [3];
        logic        dsat;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = sat32(rnd(68'(rot_reg[3*i]) + 68'(rot_reg[3*i+1]) + 68'(rot_reg[3*i+2])));
            n[i] = sat32(-68'($signed(f4_reg.a[i+1])));
        end
        dsat = d[0][32] | d[1][32] | d[2][32];
        c0_next.cmd = f4_reg.cmd;
        c0_next.ssum = m4_reg.ssum;
        c0_next.wrap = m4_reg.wrap;
        case (f4_reg.cmd)
            qau_pkg::CMD_PRODUCT:
            begin
                c0_next.r = m4_reg.rp;
                c0_next.sat = m4_reg.rp_sat;
            end
            qau_pkg::CMD_CONJUGATE:
            begin
                c0_next.r = {n[2][31:0], n[1][31:0], n[0][31:0], f4_reg.a[0]};
                c0_next.sat = n[0][32] | n[1][32] | n[2][32];
            end
            qau_pkg::CMD_NORMALIZE:
            begin
                c0_next.r = f4_reg.a;
                c0_next.sat = 1'b0;
            end
            default:
            begin
                c0_next.r = {d[2][31:0], d[1][31:0], d[0][31:0], 32'd0};
                c0_next.sat = dsat | m4_reg.coef_sat;
            end
        endcase
    end

    // square root: two radicand bits per stage
    always_comb
    begin
        logic [34:0] sh;
        logic [34:0] trial;
        for (int k = 0; k < SQS; k++)
        begin
            sh = {rem_reg[k][32:0], carry_reg[k].ssum[63-2*k -: 2]};
            trial = {1'b0, root_reg[k], 2'b01};
            if (sh >= trial)
            begin
                rem_next[k] = 34'(sh - trial);
                root_next[k] = {root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = sh[33:0];
                root_next[k] = {root_reg[k][30:0], 1'b0};
            end
        end
    end

    // round the root and set up the dividends
    always_comb
    begin
        logic [NW-1:0] num;
        logic [31:0]   m;
        logic [31:0]   a;
        carry_t        c;
        c = carry_reg[SQS];
        if (c.wrap)
            nn_next = 33'h1_0000_0000;
        else
            nn_next = {1'b0, root_reg[SQS]} + 33'(rem_reg[SQS] > {2'b00, root_reg[SQS]});
        for (int i = 0; i < 4; i++)
        begin
            a = c.r[i];
            m = a[31] ? 32'(-a) : a;
            num = (NW'(m) << FRAC_BITS) + NW'(nn_next >> 1);
            drem_init[i] = {1'b0, num[NW-1:DS]};
            dnum_init[i] = num[DS-1:0];
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb
    begin
        logic [33:0] sh;
        for (int j = 0; j < DS; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sh = {drem_reg[j][i], dnum_reg[j][i][DS-1-j]};
                if (sh >= {1'b0, nn_reg[j]})
                begin
                    drem_next[j][i] = 33'(sh - {1'b0, nn_reg[j]});
                    dq_next[j][i] = {dq_reg[j][i][DS-2:0], 1'b1};
                end
                else
                begin
                    drem_next[j][i] = sh[32:0];
                    dq_next[j][i] = {dq_reg[j][i][DS-2:0], 1'b0};
                end
            end
        end
    end

    // output select
    always_comb
    begin
        carry_t      c;
        logic [32:0] nn;
        logic [31:0] q [4];
        c = carry_reg[NCARRY-1];
        nn = nn_reg[DS];
        for (int i = 0; i < 4; i++)
        begin
            q[i] = 32'(dq_reg[DS][i]);
            if (c.r[i][31])
                q[i] = -q[i];
        end
        if (c.cmd == qau_pkg::CMD_NORMALIZE)
        begin
            if (nn == '0)
            begin
                res_next = '0;
                res_next.status = qau_pkg::STATUS_ZERO;
            end
            else
            begin
                res_next.r_w = q[0];
                res_next.r_x = q[1];
                res_next.r_y = q[2];
                res_next.r_z = q[3];
                res_next.norm_out = (|nn[32:31]) ? 31'h7fff_ffff : nn[30:0];
                res_next.status = (|nn[32:31]) ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
            end
        end
        else
        begin
            res_next.r_w = c.r[0];
            res_next.r_x = c.r[1];
            res_next.r_y = c.r[2];
            res_next.r_z = c.r[3];
            res_next.norm_out = '0;
            res_next.status = c.sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= c0_next;
            rem_reg[0] <= '0;
            root_reg[0] <= '0;
            for (int k = 1; k < NCARRY; k++)
                carry_reg[k] <= carry_reg[k-1];
            for (int k = 0; k < SQS; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                root_reg[k+1] <= root_next[k];
            end
            nn_reg[0] <= nn_next;
            drem_reg[0] <= drem_init;
            dnum_reg[0] <= dnum_init;
            dq_reg[0] <= '0;
            for (int j = 0; j < DS; j++)
            begin
                nn_reg[j+1] <= nn_reg[j];
                drem_reg[j+1] <= drem_next[j];
                dnum_reg[j+1] <= dnum_reg[j];
                dq_reg[j+1] <= dq_next[j];
            end
            res_reg <= res_next;
        end
    end

    `QAU_ASSERT_NEXT(a_accept_enters, op_valid && !op_stall, v_reg[0])
    `QAU_ASSERT_NEXT(a_stall_freezes, res_valid && res_stall, $stable(v_reg))
    `QAU_ASSERT_IMPLY(a_zero_clean, res_valid && res.status == qau_pkg::STATUS_ZERO, res.norm_out == '0 && res.r_w == '0)

endmodule
